>>> hdl/rilru_pkg.sv
// Shared types and constants for the recent-id LRU list.
package rilru_pkg;

    localparam int AGE_W  = 32;
    localparam int SLOT_W = 4;

    localparam logic [AGE_W-1:0] AGE_TOP = '1;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_AGE,
        CELL_ROTATE,
        CELL_WRITE,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGE,
        ST_SCAN,
        ST_WRITE,
        ST_SORT,
        ST_OUT
    } state_t;

endpackage

>>> hdl/recent_id_lru_list.sv
// Recent-id LRU list: top level with sequencer and the ring of list cells.
//
// Input channel (id, id_valid, id_stall): one word per used id. id_stall is
// high whenever an update or list dump is in progress; a word is taken only
// in the idle state.
// Output channel (slot, slot_id, last, res_valid, res_stall): after each
// input word the whole list goes out, ENTRIES words in ascending id order,
// slot 0 first, last set on the final word.
// Sequence: an aging step, the victim scan (the ring rotates once past
// cell 0), a replace step and the odd-even sort, after which the first
// result word shows. After the dump the block returns to idle; a new input
// word is taken only once the whole list has gone out.
// Result stall: the ring holds still and the word on the port stays put.
// Reset: cells return to ids 1..ENTRIES with ages 0..ENTRIES-1; the block
// comes up idle and ready.
module recent_id_lru_list
    import rilru_pkg::*;
#(
    parameter int ENTRIES = 12,
    parameter int ID_BITS = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ID_BITS-1:0] id,
    input  logic               id_valid,
    output logic               id_stall,
    output logic [SLOT_W-1:0]  slot,
    output logic [ID_BITS-1:0] slot_id,
    output logic               last,
    output logic               res_valid,
    input  logic               res_stall
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic [ID_BITS-1:0] key_reg;
    logic [AGE_W-1:0]   best_age_reg;
    logic [IDX_W-1:0]   vidx_reg;
    cell_ctrl_t         ctrl;
    logic               cnt_end;

    logic [ID_BITS-1:0] cell_id  [ENTRIES];
    logic [AGE_W-1:0]   cell_age [ENTRIES];

    assign cnt_end = (cnt_reg == LAST_IDX);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (id_valid)
                begin
                    state_next = ST_AGE;
                end
            end
            ST_AGE:
            begin
                state_next = ST_SCAN;
                cnt_next   = '0;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_end)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_SORT;
                cnt_next   = '0;
            end
            ST_SORT:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_end)
                begin
                    state_next = ST_OUT;
                    cnt_next   = '0;
                end
            end
            ST_OUT:
            begin
                if (!res_stall)
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (cnt_end)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // outputs and cell commands
    always_comb
    begin
        ctrl.op    = CELL_HOLD;
        ctrl.phase = cnt_reg[0];
        id_stall   = 1'b1;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                id_stall = 1'b0;
            end
            ST_AGE:
            begin
                ctrl.op = CELL_AGE;
            end
            ST_SCAN:
            begin
                ctrl.op = CELL_ROTATE;
            end
            ST_WRITE:
            begin
                ctrl.op = CELL_WRITE;
            end
            ST_SORT:
            begin
                ctrl.op = CELL_SORT;
            end
            ST_OUT:
            begin
                res_valid = 1'b1;
                if (!res_stall)
                begin
                    ctrl.op = CELL_ROTATE;
                end
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // victim scan: cell 0 shows entry cnt_reg; later entries win only if strictly older
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && id_valid)
        begin
            key_reg <= id;
        end
        if (state_reg == ST_SCAN)
        begin
            if ((cnt_reg == '0) || (cell_age[0] > best_age_reg))
            begin
                best_age_reg <= cell_age[0];
                vidx_reg     <= cnt_reg;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            rilru_cell #(
                .INDEX   (gi),
                .ENTRIES (ENTRIES),
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .key_id   (key_reg),
                .wr_sel   (vidx_reg == IDX_W'(gi)),
                .prev_id  (cell_id[(gi + ENTRIES - 1) % ENTRIES]),
                .prev_age (cell_age[(gi + ENTRIES - 1) % ENTRIES]),
                .next_id  (cell_id[(gi + 1) % ENTRIES]),
                .next_age (cell_age[(gi + 1) % ENTRIES]),
                .id       (cell_id[gi]),
                .age      (cell_age[gi])
            );
        end
    endgenerate

    assign slot    = SLOT_W'(cnt_reg);
    assign slot_id = cell_id[0];
    assign last    = (state_reg == ST_OUT) && cnt_end;

endmodule

>>> hdl/rilru_cell.sv
// One list cell: holds an id and its age, ages, rotates, takes a written id, and swaps with its neighbors.
module rilru_cell
    import rilru_pkg::*;
#(
    parameter int INDEX   = 0,
    parameter int ENTRIES = 12,
    parameter int ID_BITS = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [ID_BITS-1:0] key_id,
    input  logic               wr_sel,
    input  logic [ID_BITS-1:0] prev_id,
    input  logic [AGE_W-1:0]   prev_age,
    input  logic [ID_BITS-1:0] next_id,
    input  logic [AGE_W-1:0]   next_age,
    output logic [ID_BITS-1:0] id,
    output logic [AGE_W-1:0]   age
);

    localparam logic PARITY   = 1'((INDEX % 2));
    localparam logic HAS_NEXT = (INDEX < ENTRIES - 1);
    localparam logic HAS_PREV = (INDEX > 0);

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    logic [AGE_W-1:0]   age_reg;
    logic [AGE_W-1:0]   age_next;
    logic               is_left;
    logic               is_right;

    assign is_left  = HAS_NEXT && (ctrl.phase == PARITY);
    assign is_right = HAS_PREV && (ctrl.phase != PARITY);

    always_comb
    begin
        id_next  = id_reg;
        age_next = age_reg;
        case (ctrl.op)
            CELL_AGE:
            begin
                if (id_reg == key_id)
                begin
                    age_next = AGE_TOP;
                end
                else
                begin
                    age_next = age_reg + AGE_W'(1);
                end
            end
            CELL_ROTATE:
            begin
                id_next  = next_id;
                age_next = next_age;
            end
            CELL_WRITE:
            begin
                if (wr_sel)
                begin
                    id_next  = key_id;
                    age_next = '0;
                end
            end
            CELL_SORT:
            begin
                if (is_left && (id_reg > next_id))
                begin
                    id_next  = next_id;
                    age_next = next_age;
                end
                else if (is_right && (prev_id > id_reg))
                begin
                    id_next  = prev_id;
                    age_next = prev_age;
                end
            end
            default:
            begin
                id_next  = id_reg;
                age_next = age_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= ID_BITS'(INDEX + 1);
            age_reg <= AGE_W'(INDEX);
        end
        else
        begin
            id_reg  <= id_next;
            age_reg <= age_next;
        end
    end

    assign id  = id_reg;
    assign age = age_reg;

endmodule

>>> hdl/rilru_checker.sv
// Port-level checks for the recent-id LRU list, bound to the top level.
module rilru_checker
    import rilru_pkg::*;
#(
    parameter int ID_BITS = 6
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               id_valid,
    input logic               id_stall,
    input logic [SLOT_W-1:0]  slot,
    input logic [ID_BITS-1:0] slot_id,
    input logic               last,
    input logic               res_valid,
    input logic               res_stall
);

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(slot) && $stable(slot_id)
            && $stable(last))
        else $error("stalled result word changed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        id_valid && !id_stall |=> id_stall)
        else $error("input taken while an update is running");

    a_no_take_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> id_stall)
        else $error("input ready during list dump");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !last |=>
            res_valid && (slot == SLOT_W'($past(slot) + SLOT_W'(1))))
        else $error("list dump skipped or repeated a slot");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && last |=> !res_valid)
        else $error("result after last word of list");

endmodule

bind recent_id_lru_list rilru_checker #(.ID_BITS(ID_BITS)) u_rilru_checker (.*);
